// ===== src/htsg_pkg.sv =====
`timescale 1ns / 1ps

package htsg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 4096;

    localparam int COORD_W = 12;
    localparam int STEP_W  = 24;
    localparam int CNT_W   = 13;
    localparam int IDX_W   = 24;
    localparam int POS_W   = 40;
    localparam int PROD_W  = 36;
    localparam int DIV_NW  = 37;
    localparam int DIV_DW  = 25;
    localparam int DIST_W  = 25;
    localparam int SQ_W    = 2 * DIST_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);
    localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(1);

    typedef enum logic [2:0] {
        REG_HEX_X_STEP     = 3'd0,
        REG_HEX_Y_STEP     = 3'd1,
        REG_SQUARE_X_STEP  = 3'd2,
        REG_SQUARE_Y_STEP  = 3'd3,
        REG_COLS_FIRST     = 3'd4,
        REG_COLS_SECOND    = 3'd5,
        REG_HEX_ROW_COUNT  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [PROD_W-1:0] xs;
        logic [PROD_W-1:0] ys;
        logic              ge;
        logic [DIST_W-1:0] dxn;
    } side_t;

    function automatic logic [STEP_W-1:0] step_of(input logic [STEP_W-1:0] v);
        return (v == '0) ? STEP_W'(1) : v;
    endfunction

    function automatic logic [CNT_W-1:0] count_of(input logic [CNT_W-1:0] v);
        return (v > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : v;
    endfunction

endpackage

// ===== src/htsg_div.sv =====
`timescale 1ns / 1ps

module htsg_div #(
    parameter int NW = 37,
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW:0]   trial;
        logic          fits;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = dividend;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign fits  = trial >= {1'b0, divisor};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
                num_reg[k] <= {num_in[NW-2:0], 1'b0};
                quo_reg[k] <= {quo_in[NW-2:0], fits};
            end
        end
    end

    assign quotient  = quo_reg[NW-1];
    assign remainder = rem_reg[NW-1];

endmodule

// ===== src/hex_to_square_grid_nearest_index.sv =====
`timescale 1ns / 1ps
// Nearest hex-sample lookup for a raster of square-grid cells.
// Input transfer: square_col, square_row on in_valid/in_ready.
// Output transfer: hex_index, square_x, square_y, took_second on
// out_valid/out_ready, one result per input item, in order.
// Configuration: APB write/read of the seven grid registers at byte
// addresses 0, 4, ... 24; pready is always high. Write only while idle.
// Throughput: one item per cycle while the receiver keeps accepting results.
// Pipeline: two setup stages, the 37-stage radix-2 divider pipelines for
// the hex row and column quotients, and three stages for the index
// multiply, the distance squares and the final compare.
// Reset: all valid bits clear, registers return to steps of 1.0 and
// counts of 1. A stalled receiver freezes the whole pipeline; in_ready
// drops while a result waits, and no item is lost or repeated.
module hex_to_square_grid_nearest_index (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [htsg_pkg::COORD_W-1:0]      square_col,
    input  logic [htsg_pkg::COORD_W-1:0]      square_row,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [htsg_pkg::IDX_W-1:0]        hex_index,
    output logic [htsg_pkg::POS_W-1:0]        square_x,
    output logic [htsg_pkg::POS_W-1:0]        square_y,
    output logic                              took_second,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htsg_pkg::ADDR_W-1:0]       paddr,
    input  logic [htsg_pkg::DATA_W-1:0]       pwdata,
    output logic [htsg_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    import htsg_pkg::*;

    logic [STEP_W-1:0] hex_x_step_reg, hex_y_step_reg, square_x_step_reg, square_y_step_reg;
    logic [CNT_W-1:0]  cols_first_reg, cols_second_reg, hex_row_count_reg;
    reg_idx_t          widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_x_step_reg    <= STEP_RESET;
            hex_y_step_reg    <= STEP_RESET;
            square_x_step_reg <= STEP_RESET;
            square_y_step_reg <= STEP_RESET;
            cols_first_reg    <= CNT_RESET;
            cols_second_reg   <= CNT_RESET;
            hex_row_count_reg <= CNT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_HEX_X_STEP:    hex_x_step_reg    <= pwdata[STEP_W-1:0];
                REG_HEX_Y_STEP:    hex_y_step_reg    <= pwdata[STEP_W-1:0];
                REG_SQUARE_X_STEP: square_x_step_reg <= pwdata[STEP_W-1:0];
                REG_SQUARE_Y_STEP: square_y_step_reg <= pwdata[STEP_W-1:0];
                REG_COLS_FIRST:    cols_first_reg    <= pwdata[CNT_W-1:0];
                REG_COLS_SECOND:   cols_second_reg   <= pwdata[CNT_W-1:0];
                REG_HEX_ROW_COUNT: hex_row_count_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_HEX_X_STEP:    prdata = DATA_W'(hex_x_step_reg);
            REG_HEX_Y_STEP:    prdata = DATA_W'(hex_y_step_reg);
            REG_SQUARE_X_STEP: prdata = DATA_W'(square_x_step_reg);
            REG_SQUARE_Y_STEP: prdata = DATA_W'(square_y_step_reg);
            REG_COLS_FIRST:    prdata = DATA_W'(cols_first_reg);
            REG_COLS_SECOND:   prdata = DATA_W'(cols_second_reg);
            REG_HEX_ROW_COUNT: prdata = DATA_W'(hex_row_count_reg);
            default:           prdata = '0;
        endcase
    end

    logic [STEP_W-1:0] hx, hy, sx, sy;
    logic [CNT_W-1:0]  n_even, n_odd, n_rows;
    logic [CNT_W:0]    pair;

    assign hx     = step_of(hex_x_step_reg);
    assign hy     = step_of(hex_y_step_reg);
    assign sx     = step_of(square_x_step_reg);
    assign sy     = step_of(square_y_step_reg);
    assign n_even = count_of(cols_first_reg);
    assign n_odd  = count_of(cols_second_reg);
    assign n_rows = count_of(hex_row_count_reg);
    assign pair   = {1'b0, n_even} + {1'b0, n_odd};

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage A: positions
    logic              va_reg;
    logic [PROD_W-1:0] xs_a_reg, ys_a_reg;

    // stage B: shifted numerator
    logic              vb_reg;
    side_t             side_b_reg;
    logic [DIV_NW-1:0] nums_b_reg;
    logic [DIV_NW-1:0] xx_b;
    logic              ge_b;

    assign xx_b = {xs_a_reg, 1'b0};
    assign ge_b = xx_b >= DIV_NW'(hx);

    // divider lanes
    logic [DIV_NW-1:0] vdiv_reg;
    side_t             side_reg [DIV_NW];
    logic [DIV_NW-1:0] qy, qp, qs;
    logic [DIV_DW-1:0] ry, rp, rs;

    htsg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_row (
        .clk(clk), .en(en),
        .dividend({1'b0, side_b_reg.ys}), .divisor({1'b0, hy}),
        .quotient(qy), .remainder(ry)
    );

    htsg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_plain (
        .clk(clk), .en(en),
        .dividend({1'b0, side_b_reg.xs}), .divisor({1'b0, hx}),
        .quotient(qp), .remainder(rp)
    );

    htsg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_shift (
        .clk(clk), .en(en),
        .dividend(nums_b_reg), .divisor({hx, 1'b0}),
        .quotient(qs), .remainder(rs)
    );

    // stage C: offsets and row base
    side_t             sd;
    logic              vc_reg, odd_c_reg, last_c_reg;
    logic [PROD_W-1:0] xs_c_reg, ys_c_reg;
    logic [IDX_W-1:0]  base_c_reg, cp_c_reg, cs_c_reg;
    logic [DIST_W-1:0] dxs_c_reg, dxp_c_reg, dy1_c_reg, dy2_c_reg;
    logic [IDX_W-1:0]  half_c;
    logic [DIST_W-1:0] dy1_c;

    assign sd     = side_reg[DIV_NW-1];
    assign half_c = qy[IDX_W:1];
    assign dy1_c  = {ry[STEP_W-1:0], 1'b0};

    // stage D: squares and candidate indices
    logic              vd_reg, last_d_reg;
    logic [PROD_W-1:0] xs_d_reg, ys_d_reg;
    logic [SQ_W-1:0]   sq1x_reg, sq1y_reg, sq2x_reg, sq2y_reg;
    logic [IDX_W-1:0]  idx1_d_reg, idx2_d_reg;
    logic [DIST_W-1:0] dx1_d, dx2_d;
    logic [IDX_W-1:0]  sh_d, pl0_d, pl1_d;

    assign dx1_d = odd_c_reg ? dxs_c_reg : dxp_c_reg;
    assign dx2_d = odd_c_reg ? dxp_c_reg : dxs_c_reg;
    assign sh_d  = base_c_reg + IDX_W'(n_even) + cs_c_reg;
    assign pl0_d = base_c_reg + cp_c_reg;
    assign pl1_d = base_c_reg + IDX_W'(pair) + cp_c_reg;

    // stage E: compare and select
    logic              took_second_reg;
    logic [IDX_W-1:0]  hex_index_reg;
    logic [PROD_W-1:0] xs_e_reg, ys_e_reg;
    logic [SQ_W:0]     d1_e, d2_e;
    logic              second_e;

    assign d1_e     = {1'b0, sq1x_reg} + {1'b0, sq1y_reg};
    assign d2_e     = {1'b0, sq2x_reg} + {1'b0, sq2y_reg};
    assign second_e = !((d1_e <= d2_e) || last_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vdiv_reg      <= '0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            vdiv_reg      <= {vdiv_reg[DIV_NW-2:0], vb_reg};
            vc_reg        <= vdiv_reg[DIV_NW-1];
            vd_reg        <= vc_reg;
            out_valid_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_a_reg <= PROD_W'(square_col) * PROD_W'(sx);
            ys_a_reg <= PROD_W'(square_row) * PROD_W'(sy);

            side_b_reg.xs  <= xs_a_reg;
            side_b_reg.ys  <= ys_a_reg;
            side_b_reg.ge  <= ge_b;
            side_b_reg.dxn <= DIST_W'({1'b0, hx} - xx_b[DIST_W-1:0]);
            nums_b_reg     <= ge_b ? DIV_NW'(xx_b - DIV_NW'(hx)) : '0;

            side_reg[0] <= side_b_reg;
            for (int k = 1; k < DIV_NW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            xs_c_reg   <= sd.xs;
            ys_c_reg   <= sd.ys;
            odd_c_reg  <= qy[0];
            last_c_reg <= ({1'b0, qy} + (DIV_NW+1)'(1)) == (DIV_NW+1)'(n_rows);
            base_c_reg <= half_c * IDX_W'(pair);
            cp_c_reg   <= qp[IDX_W-1:0];
            cs_c_reg   <= sd.ge ? qs[IDX_W-1:0] : '0;
            dxs_c_reg  <= sd.ge ? rs : sd.dxn;
            dxp_c_reg  <= {rp[STEP_W-1:0], 1'b0};
            dy1_c_reg  <= dy1_c;
            dy2_c_reg  <= {hy, 1'b0} - dy1_c;

            xs_d_reg   <= xs_c_reg;
            ys_d_reg   <= ys_c_reg;
            last_d_reg <= last_c_reg;
            sq1x_reg   <= SQ_W'(dx1_d) * SQ_W'(dx1_d);
            sq1y_reg   <= SQ_W'(dy1_c_reg) * SQ_W'(dy1_c_reg);
            sq2x_reg   <= SQ_W'(dx2_d) * SQ_W'(dx2_d);
            sq2y_reg   <= SQ_W'(dy2_c_reg) * SQ_W'(dy2_c_reg);
            idx1_d_reg <= odd_c_reg ? sh_d : pl0_d;
            idx2_d_reg <= odd_c_reg ? pl1_d : sh_d;

            xs_e_reg        <= xs_d_reg;
            ys_e_reg        <= ys_d_reg;
            took_second_reg <= second_e;
            hex_index_reg   <= second_e ? idx2_d_reg : idx1_d_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hex_index   = hex_index_reg;
    assign square_x    = POS_W'(xs_e_reg);
    assign square_y    = POS_W'(ys_e_reg);
    assign took_second = took_second_reg;

    a_row_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vdiv_reg[DIV_NW-1] |-> (ry < {1'b0, hy}))
        else $error("row remainder not below hex_y_step");

    a_col_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg |-> (dxp_c_reg < {hx, 1'b0}))
        else $error("plain column offset out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg && en) |=> out_valid_reg)
        else $error("item dropped at output stage");

endmodule
